// ----- rtl/htsd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htsd_pkg
// types and constants shared by the tree stream decoder modules
// ----------------------------------------------------------------------------
package htsd_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_final;
      logic       out_run_end;
      logic [2:0] err_code;
   } rsp_type;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_HEADER    = 3'd1;
   localparam logic [2:0] ERR_ZERO_SIZE = 3'd2;
   localparam logic [2:0] ERR_TREE      = 3'd3;
   localparam logic [2:0] ERR_TOO_LONG  = 3'd4;
   localparam logic [2:0] ERR_BAD_CODE  = 3'd5;
   localparam logic [2:0] ERR_TRUNC     = 3'd6;

   localparam logic [8:0] LEN_MASK = 9'h1ff;

   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_TREE   = 3'd1;
   localparam logic [2:0] PH_SIZE   = 3'd2;
   localparam logic [2:0] PH_DECODE = 3'd3;
   localparam logic [2:0] PH_DONE   = 3'd4;
   localparam logic [2:0] PH_ERROR  = 3'd5;

   // controller to datapath
   typedef struct packed {
      logic load;      // take a new word
      logic step;      // process one bit
      logic scan;      // compare one table entry
      logic emit_done; // result taken
      logic finish;    // word finished
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_needed;  // current bit needs a table search
      logic scan_end;     // search finished
      logic scan_emit;    // current compare produces a result
      logic has_result;   // a result is waiting
      logic bits_done;    // no more bits of this word
   } sts_type;

endpackage

// ----- rtl/huffman_tree_stream_decoder_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_stream_decoder_top
// static huffman decoder with a pre-order code tree sent ahead of the data
// ----------------------------------------------------------------------------
// req channel: one packed byte per word, req_word.in_last on the final byte.
// rsp channel: decoded bytes, run end on the last word caused by a request,
// error words carry out_final set, and out_byte zero but for truncation.
// one request is worked at a time. tree bytes are walked one code bit at a
// time. data bytes take per bit a table search that reads one stored leaf
// at a time (single read port of the leaf memory).
// a result is held steady while rsp_stall is high; decoding waits on it.
// reset returns to the header phase at offset zero; the leaf memory needs no
// clearing. a byte marked last also returns the block to that state.
// ----------------------------------------------------------------------------
module huffman_tree_stream_decoder_top #(
   parameter int MAX_LEAVES    = 256,
   parameter int MAX_CODE_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  htsd_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output htsd_pkg::rsp_type rsp_word
);
   htsd_pkg::cmd_type cmd;
   htsd_pkg::sts_type sts;

   htsd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .sts      (sts),
      .cmd      (cmd)
   );

   htsd_datapath #(
      .MAX_LEAVES   (MAX_LEAVES),
      .MAX_CODE_BITS(MAX_CODE_BITS)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .req_word(req_word),
      .cmd     (cmd),
      .sts     (sts),
      .rsp_word(rsp_word)
   );

`ifndef ASSERT_OFF
   a_no_accept_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while a result is offered");
   a_err_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.err_code != htsd_pkg::ERR_NONE) |-> rsp_word.out_final)
      else $error("error word without final");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.err_code != htsd_pkg::ERR_NONE &&
       rsp_word.err_code != htsd_pkg::ERR_TRUNC) |-> rsp_word.out_byte == 8'd0)
      else $error("error word with data");
`endif
endmodule

// ----- rtl/htsd_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htsd_ram
// generic single port write, single port registered read memory
// ----------------------------------------------------------------------------
module htsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/htsd_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htsd_datapath
// stream state, tree build, leaf table and code search, one bit per step
// ----------------------------------------------------------------------------
module htsd_datapath #(
   parameter int MAX_LEAVES    = 256,
   parameter int MAX_CODE_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  htsd_pkg::req_type req_word,
   input  htsd_pkg::cmd_type cmd,
   output htsd_pkg::sts_type sts,
   output htsd_pkg::rsp_type rsp_word
);
   localparam int LW = $clog2(MAX_LEAVES);
   localparam int CW = $clog2(MAX_LEAVES + 1);
   localparam int BW = $clog2(MAX_CODE_BITS + 1);
   localparam int EW = MAX_CODE_BITS + BW + 8;

   logic [2:0]               phase_ff, phase_in;
   logic [9:0]               offset_ff, offset_in;
   logic [8:0]               hlen_ff, hlen_in;
   logic [MAX_CODE_BITS-1:0] bcode_ff, bcode_in;
   logic [BW-1:0]            bbits_ff, bbits_in;
   logic [CW-1:0]            lcount_ff, lcount_in;
   logic [15:0]              raw_ff, raw_in;
   logic [MAX_CODE_BITS-1:0] dcode_ff, dcode_in;
   logic [BW-1:0]            dbits_ff, dbits_in;
   logic [7:0]               psym_ff, psym_in;
   logic [3:0]               sbc_ff, sbc_in;
   logic [7:0]               byte_ff, byte_in;
   logic                     last_ff, last_in;
   logic [2:0]               bidx_ff, bidx_in;
   logic                     bdone_ff, bdone_in;
   logic [CW-1:0]            sidx_ff, sidx_in;
   logic                     sdone_ff, sdone_in;
   logic                     rvalid_ff, rvalid_in;
   htsd_pkg::rsp_type        rdata_ff, rdata_in;
   logic                     any_ff, any_in;

   logic          wr_en;
   logic [LW-1:0] wr_addr;
   logic [EW-1:0] wr_data, rd_data;
   logic [LW-1:0] rd_addr;
   logic          bit_val;
   logic          hit;
   logic          last_entry;
   logic [7:0]    b;
   logic [BW-1:0] tb;
   logic [BW-1:0] tz;
   logic [BW-1:0] nz;
   logic [MAX_CODE_BITS-1:0] tc;

   htsd_ram #(.WIDTH(EW), .DEPTH(MAX_LEAVES)) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign bit_val = byte_ff[3'd7 - bidx_ff];
   assign rd_addr = sidx_ff[LW-1:0];
   assign rsp_word = rdata_ff;
   assign hit = (rd_data[8 +: BW] == dbits_ff) &&
                (rd_data[8 + BW +: MAX_CODE_BITS] == dcode_ff);
   assign last_entry = (sidx_ff + CW'(1)) >= lcount_ff;

   always_comb begin
      sts.scan_needed = (phase_ff == htsd_pkg::PH_DECODE) && !bdone_ff;
      sts.scan_end    = sdone_ff;
      sts.scan_emit   = !sdone_ff &&
                        (hit || (last_entry && dbits_ff >= BW'(MAX_CODE_BITS)));
      sts.has_result  = rvalid_ff;
      sts.bits_done   = bdone_ff;
   end

   always_comb begin
      phase_in  = phase_ff;  offset_in = offset_ff; hlen_in  = hlen_ff;
      bcode_in  = bcode_ff;  bbits_in  = bbits_ff;  lcount_in = lcount_ff;
      raw_in    = raw_ff;    dcode_in  = dcode_ff;  dbits_in = dbits_ff;
      psym_in   = psym_ff;   sbc_in    = sbc_ff;    byte_in  = byte_ff;
      last_in   = last_ff;   bidx_in   = bidx_ff;   bdone_in = bdone_ff;
      sidx_in   = sidx_ff;   sdone_in  = sdone_ff;
      rvalid_in = rvalid_ff; rdata_in  = rdata_ff;  any_in   = any_ff;
      wr_en = 1'b0;
      wr_addr = lcount_ff[LW-1:0];
      wr_data = {bcode_ff, bbits_ff, psym_ff};
      b = req_word.in_byte;
      tb = bbits_ff;
      tc = bcode_ff;
      tz = '0;
      nz = '0;

      if (cmd.emit_done) begin
         rvalid_in = 1'b0;
      end

      if (cmd.load) begin
         byte_in = b;
         last_in = req_word.in_last;
         bidx_in = 3'd0;
         bdone_in = 1'b1;
         any_in = 1'b0;
         unique case (phase_ff)
            htsd_pkg::PH_HEADER: begin
               if (offset_ff == 10'd0) begin
                  hlen_in = {b[0], 8'd0};
               end else if (b[1:0] != 2'd0) begin
                  phase_in = htsd_pkg::PH_ERROR;
                  rvalid_in = 1'b1;
                  rdata_in = '{8'd0, 1'b1, 1'b0, htsd_pkg::ERR_HEADER};
               end else begin
                  hlen_in = (hlen_ff | {1'b0, b}) & htsd_pkg::LEN_MASK;
                  phase_in = htsd_pkg::PH_TREE;
               end
            end
            htsd_pkg::PH_TREE: begin
               if ({1'b0, offset_ff} >= {2'b0, hlen_ff} + 11'd2) begin
                  phase_in = htsd_pkg::PH_ERROR;
                  rvalid_in = 1'b1;
                  rdata_in = '{8'd0, 1'b1, 1'b0, htsd_pkg::ERR_TREE};
               end else begin
                  bdone_in = 1'b0;
               end
            end
            htsd_pkg::PH_SIZE: begin
               if ({1'b0, offset_ff} == {2'b0, hlen_ff} + 11'd2) begin
                  raw_in = {b, 8'd0};
               end else if ({1'b0, offset_ff} == {2'b0, hlen_ff} + 11'd3) begin
                  raw_in = raw_ff | {8'd0, b};
                  if (raw_in == 16'd0) begin
                     phase_in = htsd_pkg::PH_ERROR;
                     rvalid_in = 1'b1;
                     rdata_in = '{8'd0, 1'b1, 1'b0, htsd_pkg::ERR_ZERO_SIZE};
                  end else begin
                     phase_in = htsd_pkg::PH_DECODE;
                  end
               end
            end
            htsd_pkg::PH_DECODE: begin
               bdone_in = 1'b0;
            end
            default: begin
            end
         endcase
         if (offset_ff != 10'd1023) begin
            offset_in = offset_ff + 10'd1;
         end
      end

      if (cmd.step && phase_ff == htsd_pkg::PH_TREE) begin
         if (sbc_ff != 4'd0) begin
            psym_in = psym_ff | ({7'd0, bit_val} << (3'd0 - sbc_ff[2:0]));
            sbc_in = sbc_ff - 4'd1;
            if (sbc_ff == 4'd1) begin
               if (lcount_ff >= CW'(MAX_LEAVES)) begin
                  phase_in = htsd_pkg::PH_ERROR;
                  rvalid_in = 1'b1;
                  rdata_in = '{8'd0, 1'b1, 1'b0, htsd_pkg::ERR_TREE};
               end else begin
                  wr_en = 1'b1;
                  wr_data = {bcode_ff, bbits_ff, psym_in};
                  lcount_in = lcount_ff + CW'(1);
                  // climb past trailing zeros, never above the root
                  tz = BW'(MAX_CODE_BITS);
                  for (int k = MAX_CODE_BITS - 1; k >= 0; k--) begin
                     if (bcode_ff[k]) begin
                        tz = BW'(k);
                     end
                  end
                  nz = (tz > bbits_ff) ? bbits_ff : tz;
                  tb = bbits_ff - nz;
                  tc = bcode_ff >> nz;
                  bbits_in = tb;
                  if (tb == '0) begin
                     bcode_in = tc;
                     phase_in = htsd_pkg::PH_SIZE;
                  end else begin
                     bcode_in = tc - MAX_CODE_BITS'(1);
                  end
               end
            end
         end else if (bit_val) begin
            if (bbits_ff >= BW'(MAX_CODE_BITS)) begin
               phase_in = htsd_pkg::PH_ERROR;
               rvalid_in = 1'b1;
               rdata_in = '{8'd0, 1'b1, 1'b0, htsd_pkg::ERR_TOO_LONG};
            end else begin
               bcode_in = {bcode_ff[MAX_CODE_BITS-2:0], 1'b1};
               bbits_in = bbits_ff + BW'(1);
            end
         end else begin
            psym_in = 8'd0;
            sbc_in = 4'd8;
         end
         if (bidx_ff == 3'd7 || phase_in != htsd_pkg::PH_TREE) begin
            bdone_in = 1'b1;
         end
         bidx_in = bidx_ff + 3'd1;
      end

      if (cmd.step && phase_ff == htsd_pkg::PH_DECODE) begin
         // shift in the bit and start the table search
         dcode_in = {dcode_ff[MAX_CODE_BITS-2:0], bit_val};
         dbits_in = dbits_ff + BW'(1);
         sidx_in = '0;
         sdone_in = (lcount_ff == '0);
      end

      if (cmd.scan && !sdone_ff) begin
         if (hit) begin
            raw_in = raw_ff - 16'd1;
            dcode_in = '0;
            dbits_in = '0;
            rvalid_in = 1'b1;
            rdata_in = '{rd_data[7:0], (raw_in == 16'd0), 1'b0, htsd_pkg::ERR_NONE};
            if (raw_in == 16'd0) begin
               phase_in = htsd_pkg::PH_DONE;
            end
            sdone_in = 1'b1;
         end else if (last_entry) begin
            sdone_in = 1'b1;
            if (dbits_ff >= BW'(MAX_CODE_BITS)) begin
               phase_in = htsd_pkg::PH_ERROR;
               rvalid_in = 1'b1;
               rdata_in = '{8'd0, 1'b1, 1'b0, htsd_pkg::ERR_BAD_CODE};
            end
         end else begin
            sidx_in = sidx_ff + CW'(1);
         end
         if (sdone_in) begin
            if (bidx_ff == 3'd7 || phase_in != htsd_pkg::PH_DECODE) begin
               bdone_in = 1'b1;
            end
            bidx_in = bidx_ff + 3'd1;
         end
      end

      if (rvalid_in && !rvalid_ff) begin
         any_in = 1'b1;
      end

      // word finished: mark run end, truncation, stream restart
      if (cmd.finish) begin
         if (last_ff && phase_ff != htsd_pkg::PH_DONE &&
             phase_ff != htsd_pkg::PH_ERROR) begin
            rdata_in = '{rdata_ff.out_byte, 1'b1, 1'b1, htsd_pkg::ERR_TRUNC};
            if (!any_ff) begin
               rdata_in.out_byte = 8'd0;
            end
            rvalid_in = 1'b1;
         end else if (any_ff) begin
            rdata_in.out_run_end = 1'b1;
            rvalid_in = 1'b1;
         end
         if (last_ff) begin
            phase_in = htsd_pkg::PH_HEADER; offset_in = '0; hlen_in = '0;
            bcode_in = MAX_CODE_BITS'(1); bbits_in = BW'(1); lcount_in = '0;
            raw_in = '0; dcode_in = '0; dbits_in = '0; psym_in = '0; sbc_in = '0;
         end
         any_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= htsd_pkg::PH_HEADER; offset_ff <= '0; hlen_ff <= '0;
         bcode_ff <= MAX_CODE_BITS'(1); bbits_ff <= BW'(1); lcount_ff <= '0;
         raw_ff <= '0; dcode_ff <= '0; dbits_ff <= '0; psym_ff <= '0; sbc_ff <= '0;
         bdone_ff <= 1'b1; sdone_ff <= 1'b1;
         rvalid_ff <= 1'b0; any_ff <= 1'b0; last_ff <= 1'b0;
         bidx_ff <= '0; sidx_ff <= '0;
      end else begin
         phase_ff <= phase_in; offset_ff <= offset_in; hlen_ff <= hlen_in;
         bcode_ff <= bcode_in; bbits_ff <= bbits_in; lcount_ff <= lcount_in;
         raw_ff <= raw_in; dcode_ff <= dcode_in; dbits_ff <= dbits_in;
         psym_ff <= psym_in; sbc_ff <= sbc_in;
         bdone_ff <= bdone_in; sdone_ff <= sdone_in;
         rvalid_ff <= rvalid_in; any_ff <= any_in; last_ff <= last_in;
         bidx_ff <= bidx_in; sidx_ff <= sidx_in;
      end
      byte_ff <= byte_in;
      rdata_ff <= rdata_in;
   end
endmodule

// ----- rtl/htsd_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htsd_ctrl
// sequencer: takes a word, walks its bits, searches the table, hands results
// ----------------------------------------------------------------------------
module htsd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  htsd_pkg::sts_type sts,
   output htsd_pkg::cmd_type cmd
);
   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_BIT    = 7'b0000010,
      S_READ   = 7'b0000100,
      S_CMP    = 7'b0001000,
      S_OUT    = 7'b0010000,
      S_FINISH = 7'b0100000,
      S_LAST   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_BIT;
            end
         end
         S_BIT: begin
            if (sts.bits_done) begin
               state_in = S_FINISH;
            end else begin
               cmd.step = 1'b1;
               state_in = sts.scan_needed ? S_READ : S_BIT;
            end
         end
         S_READ: begin
            if (sts.scan_end) begin
               state_in = S_BIT;
            end else begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (sts.scan_emit && sts.has_result) begin
               state_in = S_OUT;
            end else begin
               cmd.scan = 1'b1;
               state_in = S_READ;
            end
         end
         S_OUT: begin
            // another result follows, so the held one is not the run end
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               cmd.emit_done = 1'b1;
               state_in = S_CMP;
            end
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in = S_LAST;
         end
         S_LAST: begin
            if (sts.has_result) begin
               rsp_valid = 1'b1;
               if (!rsp_stall) begin
                  cmd.emit_done = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the tree stream decoder against a built-in model of its decoding
// ----------------------------------------------------------------------------
// whole packed streams are built here: header, pre-order code tree, size and
// data codes, along with broken and cut streams and plain noise. every
// accepted byte runs through the model, and each result word is checked
// field by field against the oldest expected word. both channels idle and
// stall at random.
// ----------------------------------------------------------------------------
module tb;

   localparam int LEAF_LIMIT = 256;
   localparam int CODE_LIMIT = 32;
   localparam int IDLE_LIMIT = 60000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   htsd_pkg::req_type req_word;
   logic              rsp_valid;
   logic              rsp_stall;
   htsd_pkg::rsp_type rsp_word;

   huffman_tree_stream_decoder_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
   );

   // model state
   logic [2:0]  ph;
   int          ofs;
   logic [8:0]  hlen;
   logic [31:0] bcode;
   int          bbits;
   logic [31:0] lt_code [LEAF_LIMIT];
   int          lt_len  [LEAF_LIMIT];
   logic [7:0]  lt_sym  [LEAF_LIMIT];
   int          lcount;
   logic [15:0] raw_left;
   logic [31:0] dcode;
   int          dbits;
   logic [7:0]  psym;
   int          sym_bits;

   htsd_pkg::rsp_type step_words[$];
   htsd_pkg::rsp_type expected_words[$];

   // stream builder
   bit          tree_bits[$];
   logic [31:0] leaf_codes[$];
   int          leaf_lens[$];
   logic [7:0]  stream_bytes[$];

   int  errors = 0;
   int  bytes_sent = 0;
   int  idle_cycles = 0;
   int  stall_left = 0;
   bit  no_idle = 0;

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   task automatic model_clear();
      ph = htsd_pkg::PH_HEADER; ofs = 0; hlen = '0; bcode = 32'd1; bbits = 1; lcount = 0;
      raw_left = '0; dcode = '0; dbits = 0; psym = '0; sym_bits = 0;
   endtask

   task automatic put_word(logic [7:0] b, logic fin, logic [2:0] err);
      htsd_pkg::rsp_type w;
      w.out_byte = b; w.out_final = fin; w.out_run_end = 1'b0; w.err_code = err;
      step_words.push_back(w);
   endtask

   task automatic raise_error(logic [2:0] err);
      ph = htsd_pkg::PH_ERROR;
      put_word(8'd0, 1'b1, err);
   endtask

   task automatic tree_bit(bit v);
      if (sym_bits != 0) begin
         psym[8 - sym_bits] = v;
         sym_bits--;
         if (sym_bits != 0) return;
         if (lcount >= LEAF_LIMIT) begin
            raise_error(htsd_pkg::ERR_TREE);
            return;
         end
         lt_code[lcount] = bcode; lt_len[lcount] = bbits; lt_sym[lcount] = psym;
         lcount++;
         while (!bcode[0] && bbits != 0) begin
            bbits--;
            bcode = bcode >> 1;
         end
         if (bbits == 0) begin
            ph = htsd_pkg::PH_SIZE;
            return;
         end
         bcode = bcode - 32'd1;
      end else if (v) begin
         if (bbits >= CODE_LIMIT) begin
            raise_error(htsd_pkg::ERR_TOO_LONG);
            return;
         end
         bcode = {bcode[30:0], 1'b1};
         bbits++;
      end else begin
         psym = '0;
         sym_bits = 8;
      end
   endtask

   task automatic decode_bit(bit v);
      dcode = {dcode[30:0], v};
      dbits++;
      for (int i = 0; i < lcount; i++) begin
         if (lt_len[i] == dbits && lt_code[i] == dcode) begin
            raw_left = raw_left - 16'd1;
            dcode = '0; dbits = 0;
            if (raw_left == 16'd0) begin
               ph = htsd_pkg::PH_DONE;
               put_word(lt_sym[i], 1'b1, htsd_pkg::ERR_NONE);
            end else begin
               put_word(lt_sym[i], 1'b0, htsd_pkg::ERR_NONE);
            end
            return;
         end
      end
      if (dbits >= CODE_LIMIT) raise_error(htsd_pkg::ERR_BAD_CODE);
   endtask

   task automatic predict_byte(logic [7:0] b, logic last);
      htsd_pkg::rsp_type w;
      step_words.delete();
      case (ph)
         htsd_pkg::PH_HEADER: begin
            if (ofs == 0) hlen = {b[0], 8'h00};
            else if (b[1:0] != 2'd0) raise_error(htsd_pkg::ERR_HEADER);
            else begin
               hlen = hlen | {1'b0, b};
               ph = htsd_pkg::PH_TREE;
            end
         end
         htsd_pkg::PH_TREE: begin
            if (ofs >= int'(hlen) + 2) raise_error(htsd_pkg::ERR_TREE);
            else
               for (int i = 7; i >= 0 && ph == htsd_pkg::PH_TREE; i--) tree_bit(b[i]);
         end
         htsd_pkg::PH_SIZE: begin
            if (ofs == int'(hlen) + 2) raw_left = {b, 8'h00};
            else if (ofs == int'(hlen) + 3) begin
               raw_left = raw_left | {8'h00, b};
               if (raw_left == 16'd0) raise_error(htsd_pkg::ERR_ZERO_SIZE);
               else ph = htsd_pkg::PH_DECODE;
            end
         end
         htsd_pkg::PH_DECODE: begin
            for (int i = 7; i >= 0 && ph == htsd_pkg::PH_DECODE; i--) decode_bit(b[i]);
         end
         default: ;
      endcase
      if (ofs < 1023) ofs++;
      if (last) begin
         if (ph != htsd_pkg::PH_DONE && ph != htsd_pkg::PH_ERROR) begin
            if (step_words.size() > 0) begin
               w = step_words[$];
               w.out_final = 1'b1; w.err_code = htsd_pkg::ERR_TRUNC;
               step_words[$] = w;
            end else begin
               put_word(8'd0, 1'b1, htsd_pkg::ERR_TRUNC);
            end
         end
         model_clear();
      end
      if (step_words.size() > 0) begin
         w = step_words[$];
         w.out_run_end = 1'b1;
         step_words[$] = w;
      end
      foreach (step_words[i]) expected_words.push_back(step_words[i]);
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   task automatic send_byte(logic [7:0] b, logic last);
      int gap;
      req_valid <= 1;
      req_word <= '{in_byte: b, in_last: last};
      do @(posedge clock); while (req_stall);
      predict_byte(b, last);
      bytes_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic grow(logic [31:0] code, int depth, int budget, int mode);
      logic [7:0] sym;
      int a;
      if (budget == 1) begin
         sym = 8'($urandom);
         tree_bits.push_back(1'b0);
         for (int k = 0; k < 8; k++) tree_bits.push_back(sym[k]);
         leaf_codes.push_back(code);
         leaf_lens.push_back(depth);
      end else begin
         tree_bits.push_back(1'b1);
         a = (mode == 1) ? 1 : (mode == 2) ? budget / 2 : $urandom_range(1, budget - 1);
         grow({code[30:0], 1'b1}, depth + 1, a, mode);
         grow({code[30:0], 1'b0}, depth + 1, budget - a, mode);
      end
   endtask

   function automatic void pack_bits();
      logic [7:0] b;
      while (tree_bits.size() % 8 != 0) tree_bits.push_back(1'($urandom_range(0, 1)));
      while (tree_bits.size() > 0) begin
         for (int k = 7; k >= 0; k--) b[k] = tree_bits.pop_front();
         stream_bytes.push_back(b);
      end
   endfunction

   // len_set < 0 picks a fitting length; cut drops bytes from the end
   task automatic run_stream(int leaves, int mode, int size_field, int nsyms, int gap_words,
                             int tail, int cut, bit bad_header, int len_set);
      int tbytes, len, idx;
      logic [6:0] flags;
      tree_bits.delete(); leaf_codes.delete(); leaf_lens.delete(); stream_bytes.delete();
      grow(32'd1, 1, (mode == 1) ? leaves - 1 : leaves / 2, mode);
      grow(32'd0, 1, (mode == 1) ? 1 : leaves - leaves / 2, mode);
      tbytes = (tree_bits.size() + 7) / 8;
      len = (len_set >= 0) ? len_set : ((tbytes + 3) / 4 + gap_words) * 4;
      if (len > 508) len = 508;
      flags = 7'($urandom);
      stream_bytes.push_back({flags, len[8]});
      stream_bytes.push_back(bad_header ? (len[7:0] | 8'($urandom_range(1, 3))) : len[7:0]);
      pack_bits();
      for (int i = tbytes; i < len; i++) stream_bytes.push_back(8'($urandom));
      stream_bytes.push_back(size_field[15:8]);
      stream_bytes.push_back(size_field[7:0]);
      for (int s = 0; s < nsyms; s++) begin
         idx = $urandom_range(0, leaf_codes.size() - 1);
         for (int k = leaf_lens[idx] - 1; k >= 0; k--)
            if (k < 32) tree_bits.push_back(leaf_codes[idx][k]);
      end
      pack_bits();
      repeat (tail) stream_bytes.push_back(8'($urandom));
      repeat (cut) if (stream_bytes.size() > 1) void'(stream_bytes.pop_back());
      foreach (stream_bytes[i]) send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
   endtask

   task automatic run_noise(int n);
      for (int i = 0; i < n; i++) send_byte(8'($urandom), i == n - 1);
   endtask

   task automatic drain();
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   task automatic test_basic();
      no_idle = 1;
      run_stream(2, 0, 8, 8, 0, 0, 0, 0, -1);
      run_stream(3, 0, 5, 5, 1, 2, 0, 0, -1);
      no_idle = 0;
      run_stream(5, 0, 6, 6, 2, 3, 0, 0, -1);
   endtask

   task automatic test_errors();
      run_stream(3, 0, 4, 4, 0, 1, 0, 1, -1);
      run_stream(3, 0, 0, 3, 0, 1, 0, 0, -1);
      run_stream(4, 0, 4, 4, 0, 1, 0, 0, 0);
      run_stream(34, 1, 3, 3, 0, 0, 0, 0, -1);
   endtask

   task automatic test_truncation();
      run_stream(2, 0, 16, 16, 0, 0, 1, 0, -1);
      run_stream(3, 0, 4, 4, 1, 0, 0, 0, -1);
      run_stream(4, 0, 16'hffff, 6, 0, 0, 0, 0, -1);
      run_noise(1);
   endtask

   // a full table of leaves followed by one too many
   task automatic test_leaf_limit();
      run_stream(257, 2, 3, 3, 0, 0, 0, 0, -1);
   endtask

   task automatic test_random();
      int r, leaves;
      while (bytes_sent < 520) begin
         r = $urandom_range(0, 99);
         no_idle = ($urandom_range(0, 9) == 0);
         leaves = $urandom_range(2, 12);
         if (r < 80)
            run_stream(leaves, 0, $urandom_range(1, 12), 12,
                       $urandom_range(0, 2), $urandom_range(0, 2), 0, 0, -1);
         else if (r < 88)
            run_stream(leaves, 0, $urandom_range(4, 12), 4, 0, 0, $urandom_range(0, 2), 0, -1);
         else if (r < 94)
            run_stream(leaves, 0, $urandom_range(0, 3), 3, 0, 0, 0,
                       $urandom_range(0, 1), $urandom_range(0, 1) * 4);
         else
            run_noise($urandom_range(1, 10));
      end
      no_idle = 0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else if (no_idle) begin
         rsp_stall <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1;
      end else if ($urandom_range(0, 99) < 25) begin
         stall_left <= ($urandom_range(0, 99) < 10) ? $urandom_range(5, 40) : $urandom_range(0, 2);
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
      end
   end

   always @(posedge clock) begin
      htsd_pkg::rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected word %h", $time, rsp_word);
            errors++;
         end else begin
            e = expected_words.pop_front();
            if (rsp_word.out_byte !== e.out_byte) begin
               $display("%0t: out_byte exp %h got %h", $time, e.out_byte, rsp_word.out_byte);
               errors++;
            end
            if (rsp_word.out_final !== e.out_final) begin
               $display("%0t: out_final exp %b got %b", $time, e.out_final, rsp_word.out_final);
               errors++;
            end
            if (rsp_word.out_run_end !== e.out_run_end) begin
               $display("%0t: out_run_end exp %b got %b", $time, e.out_run_end,
                        rsp_word.out_run_end);
               errors++;
            end
            if (rsp_word.err_code !== e.err_code) begin
               $display("%0t: err_code exp %0d got %0d", $time, e.err_code, rsp_word.err_code);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      reset = 1;
      req_valid = 0;
      req_word = '0;
      model_clear();
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_basic();
      test_errors();
      test_truncation();
      test_leaf_limit();
      test_random();
      req_valid <= 0;
      drain();
      repeat (5000) @(posedge clock);
      if (expected_words.size() != 0) begin
         $display("%0t: %0d words never arrived", $time, expected_words.size());
         errors++;
      end
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
